>>> sv/sign_magnitude_q10_21_alu_macros.svh
// Assertion macros for the sign-magnitude Q10.21 ALU.
// No dependencies; taken in by the top level.
`ifndef SIGN_MAGNITUDE_Q10_21_ALU_MACROS_SVH
`define SIGN_MAGNITUDE_Q10_21_ALU_MACROS_SVH
`ifndef SYNTH
`define SMQ_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SMQ_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SMQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> sv/smq_pkg.sv
// Package: beat types, opcodes, widths for the sign-magnitude Q10.21 ALU.
// No dependencies.
package smq_pkg;
    localparam int WORD_W = 32;
    localparam int MAG_W = 31;
    localparam int FRAC_BITS = 21;
    localparam int DIV_STAGES = 53;
    localparam int PIPE_DEPTH = DIV_STAGES + 1;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] result_word;
        logic        a_less;
        logic        a_equal;
        logic        a_greater;
    } out_beat_t;

    function automatic logic [31:0] to_twos(input logic [31:0] w);
        logic [31:0] r;
        r = w[31] ? (~w + 32'h8000_0001) : w;
        return r;
    endfunction
endpackage

>>> sv/smq_mul.sv
// Pipelined 31x31 magnitude multiplier, split into partial products.
// Depends on smq_pkg.
module smq_mul #(
    parameter int LAT = smq_pkg::PIPE_DEPTH
) (
    input  logic        clk,
    input  logic [30:0] ma,
    input  logic [30:0] mb,
    output logic [31:0] prod
);
    logic [30:0] ma_reg, mb_reg;
    logic [46:0] plo_reg;
    logic [45:0] phi_reg;
    logic [61:0] sum_reg;
    logic [31:0] dly_reg [LAT-4];

    // product lines up with the operands delayed by LAT-1 registers
    always_ff @(posedge clk)
    begin
        ma_reg  <= ma;
        mb_reg  <= mb;
        plo_reg <= 47'(ma_reg) * 47'(mb_reg[15:0]);
        phi_reg <= 46'(ma_reg) * 46'(mb_reg[30:16]);
        sum_reg <= {15'd0, plo_reg} + {phi_reg, 16'd0};
        dly_reg[0] <= sum_reg[52:21];
        for (int i = 1; i < LAT - 4; i++)
        begin
            dly_reg[i] <= dly_reg[i-1];
        end
    end

    assign prod = dly_reg[LAT-5];
endmodule

>>> sv/smq_div.sv
// Restoring divider, one quotient bit per stage: (ma << 21) / mb.
// Depends on smq_pkg.
module smq_div #(
    parameter int STAGES = smq_pkg::DIV_STAGES
) (
    input  logic        clk,
    input  logic [30:0] ma,
    input  logic [30:0] mb,
    output logic [31:0] quot
);
    // dividend is 52 bits; one stage per bit plus an input register
    logic [51:0] num_reg [STAGES];
    logic [30:0] rem_reg [STAGES];
    logic [30:0] den_reg [STAGES];

    always_ff @(posedge clk)
    begin
        num_reg[0] <= {ma, 21'd0};
        rem_reg[0] <= '0;
        den_reg[0] <= mb;
        for (int i = 1; i < STAGES; i++)
        begin
            logic [31:0] t;
            t = {rem_reg[i-1], num_reg[i-1][51]};
            den_reg[i] <= den_reg[i-1];
            if (t >= {1'b0, den_reg[i-1]})
            begin
                rem_reg[i] <= 31'(t - {1'b0, den_reg[i-1]});
                num_reg[i] <= {num_reg[i-1][50:0], 1'b1};
            end
            else
            begin
                rem_reg[i] <= t[30:0];
                num_reg[i] <= {num_reg[i-1][50:0], 1'b0};
            end
        end
    end

    assign quot = num_reg[STAGES-1][31:0];
endmodule

>>> sv/sign_magnitude_q10_21_alu.sv
// Sign-magnitude Q10.21 ALU, fully pipelined.
// Throughput: one beat per cycle; done and result are registered outputs.
// busy is tied low: the divider (one quotient bit per stage) sets the depth.
// Reset clears the valid pipeline only; the receiver cannot stall.
// Depends on smq_pkg, smq_mul, smq_div, macros header.
`include "sign_magnitude_q10_21_alu_macros.svh"
module sign_magnitude_q10_21_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  smq_pkg::in_beat_t  operands,
    output logic               done,
    output smq_pkg::out_beat_t result
);
    localparam int DIV_STAGES = smq_pkg::DIV_STAGES;
    localparam int PIPE_DEPTH = smq_pkg::PIPE_DEPTH;

    logic [PIPE_DEPTH-2:0] vld_reg;
    smq_pkg::in_beat_t     beat_reg [PIPE_DEPTH-1];
    logic [31:0] prod, quot;

    assign busy = 1'b0;

    // both units deliver in step with beat_reg[PIPE_DEPTH-2]
    smq_mul #(.LAT(PIPE_DEPTH)) u_mul (
        .clk(clk), .ma(operands.operand_a[30:0]), .mb(operands.operand_b[30:0]), .prod(prod)
    );
    smq_div #(.STAGES(DIV_STAGES)) u_div (
        .clk(clk), .ma(operands.operand_a[30:0]), .mb(operands.operand_b[30:0]), .quot(quot)
    );

    // valid travels with the operands; beat_reg feeds the final stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-3:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg[0] <= operands;
        for (int i = 1; i < PIPE_DEPTH - 1; i++)
        begin
            beat_reg[i] <= beat_reg[i-1];
        end
    end

    // output stage: add/sub/neg, select of the mul and div results, and compares on the delayed operands
    smq_pkg::in_beat_t  fin;
    smq_pkg::out_beat_t res_next, res_reg;
    logic               done_reg;
    logic [31:0] ta, tb, tbn, ka, kb, sgn;

    always_comb
    begin
        fin = beat_reg[PIPE_DEPTH-2];
        ta  = smq_pkg::to_twos(fin.operand_a);
        tb  = smq_pkg::to_twos(fin.operand_b);
        tbn = smq_pkg::to_twos(fin.operand_b ^ 32'h8000_0000);
        ka  = ta ^ 32'h8000_0000;
        kb  = tb ^ 32'h8000_0000;
        sgn = (fin.operand_a ^ fin.operand_b) & 32'h8000_0000;
        case (fin.op)
            smq_pkg::OP_ADD: res_next.result_word = smq_pkg::to_twos(ta + tb);
            smq_pkg::OP_SUB: res_next.result_word = smq_pkg::to_twos(ta + tbn);
            smq_pkg::OP_MUL: res_next.result_word = prod | sgn;
            smq_pkg::OP_DIV: res_next.result_word =
                (fin.operand_b[30:0] == '0) ? (32'h7FFF_FFFF | sgn) : (quot | sgn);
            smq_pkg::OP_NEG: res_next.result_word = fin.operand_a ^ 32'h8000_0000;
            default:         res_next.result_word = fin.operand_a;
        endcase
        res_next.a_less    = ka < kb;
        res_next.a_equal   = fin.operand_a == fin.operand_b;
        res_next.a_greater = ka > kb;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[PIPE_DEPTH-2];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    `SMQ_ASSERT_IMPL(a_flags_excl, clk, rst_n, done |-> !(result.a_less && result.a_greater), "less and greater both set")
    `SMQ_ASSERT_IMPL(a_eq_not_lt, clk, rst_n, (done && result.a_equal) |-> !result.a_less, "equal words flagged less")
    `SMQ_ASSERT_NEXT(a_vld_flow, clk, rst_n, vld_reg[PIPE_DEPTH-2], done, "valid lost at output stage")
endmodule
